### rtl/unison_wavetable_crossfade_oscillator_defines.svh
// Assertion macros for the unison wavetable oscillator checks
`ifndef UNISON_WAVETABLE_CROSSFADE_OSCILLATOR_DEFINES_SVH
`define UNISON_WAVETABLE_CROSSFADE_OSCILLATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UWCO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uwco check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define UWCO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uwco check failed");

`endif

### rtl/uwco_pkg.sv
// Shared constants, types and codes of the unison wavetable oscillator
`default_nettype none

package uwco_pkg;

    localparam int TABLE_DEPTH   = 2048;
    localparam int MAX_VOICES    = 8;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;

    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int PHASE_W   = ADDR_W + FRACTION_BITS;
    localparam int INC_W     = 27;
    localparam int DET_W     = 17;
    localparam int FADE_W    = 17;
    localparam int VC_W      = 4;
    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W     = 2;
    localparam int Q16_BITS  = 16;

    localparam int INTERP_W = SAMPLE_BITS + FRACTION_BITS;
    localparam int LERP_W   = INTERP_W + 2;
    localparam int MIX_W    = INTERP_W + Q16_BITS;
    localparam int TERM_W   = MIX_W - FRACTION_BITS;
    localparam int PROD_W   = INC_W + DET_W;
    localparam int ACC_W    = PHASE_W + Q16_BITS;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_TICK  = 2'd0;
    localparam cmd_t CMD_WR_A  = 2'd1;
    localparam cmd_t CMD_WR_B  = 2'd2;
    localparam cmd_t CMD_CLEAR = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_INC    = 2'd0;
    localparam cfg_idx_t REG_DET    = 2'd1;
    localparam cfg_idx_t REG_FADE   = 2'd2;
    localparam cfg_idx_t REG_VCOUNT = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    localparam int      SAMPLE_MAX_I = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam sample_t SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam sample_t SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    localparam logic [Q16_BITS:0]      ONE_Q16  = {1'b1, {Q16_BITS{1'b0}}};
    localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

endpackage

`default_nettype wire

### rtl/unison_wavetable_crossfade_oscillator.sv
// Unison wavetable oscillator: two crossfaded tables, per-voice phase, averaged mix
//
// Channel  Dir  Handshake            Beat payload
// in       in   in_valid / in_ready  command, table_address, table_value
// out      out  out_valid / out_ready audio_sample
// cfg      in   cfg_we               cfg_index, cfg_data
//
// Table writes and phase clears leave the block ready again in the next cycle; a tick
// steps through the N active voices in turn, each through the phase memory, the
// single table read port and the shared lerp multipliers, then runs a restoring
// divide by N, one quotient bit per cycle.
// Reset clears control state and phase valid bits at once; there is no clearing pass.
// A finished sample sits in the output register; a tick stalls in its last cycle
// until the previous beat has been taken.
`default_nettype none

module unison_wavetable_crossfade_oscillator #(
    parameter int MAX_VOICES = uwco_pkg::MAX_VOICES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire uwco_pkg::cmd_t                  command,
    input  wire logic [uwco_pkg::ADDR_W-1:0]     table_address,
    input  wire uwco_pkg::sample_t               table_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output uwco_pkg::sample_t                    audio_sample,
    input  wire logic                            cfg_we,
    input  wire uwco_pkg::cfg_idx_t              cfg_index,
    input  wire logic [uwco_pkg::CFG_W-1:0]      cfg_data
);

    localparam int SB     = uwco_pkg::SAMPLE_BITS;
    localparam int FB     = uwco_pkg::FRACTION_BITS;
    localparam int AW     = uwco_pkg::ADDR_W;
    localparam int PW     = uwco_pkg::PHASE_W;
    localparam int IW     = uwco_pkg::INTERP_W;
    localparam int LW     = uwco_pkg::LERP_W;
    localparam int MW     = uwco_pkg::MIX_W;
    localparam int ACC_W  = uwco_pkg::ACC_W;
    localparam int PROD_W = uwco_pkg::PROD_W;
    localparam int VW     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW     = $clog2(MAX_VOICES + 1);
    localparam int TOT_W  = uwco_pkg::TERM_W + VW;
    localparam int MAG_W  = TOT_W - uwco_pkg::Q16_BITS;
    localparam int DC_W   = $clog2(MAG_W);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_PH_RD    = 4'd2;
    localparam logic [3:0] S_IDX      = 4'd3;
    localparam logic [3:0] S_NXT      = 4'd4;
    localparam logic [3:0] S_LERP     = 4'd5;
    localparam logic [3:0] S_MIX      = 4'd6;
    localparam logic [3:0] S_SUM      = 4'd7;
    localparam logic [3:0] S_ACC      = 4'd8;
    localparam logic [3:0] S_DIV_INIT = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    // control
    logic [3:0]                   state_reg, state_next;
    logic [VW-1:0]                voice_reg, voice_next;
    logic [MAX_VOICES-1:0]        phv_reg, phv_next;
    logic [uwco_pkg::INC_W-1:0]   inc_reg, inc_next;
    logic [uwco_pkg::DET_W-1:0]   det_reg, det_next;
    logic [uwco_pkg::FADE_W-1:0]  fade_reg, fade_next;
    logic [uwco_pkg::VC_W-1:0]    vc_reg, vc_next;
    logic [DC_W-1:0]              dcnt_reg, dcnt_next;
    logic                         out_valid_reg, out_valid_next;

    // datapath
    logic [ACC_W-1:0]             prod_reg, prod_next;
    logic [ACC_W-1:0]             step_acc_reg, step_acc_next;
    logic [FB-1:0]                frac_reg, frac_next;
    logic [AW-1:0]                nxt_reg, nxt_next;
    logic signed [IW-1:0]         i1_reg, i1_next, i2_reg, i2_next;
    logic signed [MW-1:0]         m1_reg, m1_next, m2_reg, m2_next;
    logic signed [MW-1:0]         mix_reg, mix_next;
    logic signed [TOT_W-1:0]      total_reg, total_next;
    logic                         neg_reg, neg_next;
    logic [MAG_W-1:0]             quo_reg, quo_next;
    logic [CW-1:0]                rem_reg, rem_next;
    uwco_pkg::sample_t            sample_reg, sample_next;

    // memories
    logic [2*SB-1:0]              tbl_mem [uwco_pkg::TABLE_DEPTH];
    logic [2*SB-1:0]              tbl_q_reg;
    logic [PW-1:0]                ph_mem [MAX_VOICES];
    logic [PW-1:0]                ph_q_reg;

    logic                         in_acc;
    logic                         tbl_we_a, tbl_we_b, ph_we;
    logic [AW-1:0]                tbl_rd_addr;
    logic [PW-1:0]                ph_cur, ph_new;
    logic [uwco_pkg::DET_W-1:0]   det_sat;
    logic [uwco_pkg::FADE_W-1:0]  fade_sat, fade_inv;
    logic [CW-1:0]                cnt_sat;
    logic                         last_voice;
    logic [PROD_W-1:0]            prod_full;
    logic [FB:0]                  lerp_w;
    logic signed [SB-1:0]         t1, t2;
    logic signed [LW-1:0]         p1, p2, s1, s2;
    logic signed [MW-1:0]         q1, q2;
    logic [TOT_W-1:0]             absv;
    logic [CW:0]                  div_sh;
    logic                         div_ge;
    logic                         pos_big, neg_big;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_acc       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign audio_sample = sample_reg;

    assign tbl_we_a = in_acc && (command == uwco_pkg::CMD_WR_A);
    assign tbl_we_b = in_acc && (command == uwco_pkg::CMD_WR_B);
    assign ph_we    = (state_reg == S_IDX);

    assign det_sat  = (det_reg > uwco_pkg::ONE_Q16) ? uwco_pkg::ONE_Q16 : det_reg;
    assign fade_sat = (fade_reg > uwco_pkg::ONE_Q16) ? uwco_pkg::ONE_Q16 : fade_reg;
    assign fade_inv = uwco_pkg::ONE_Q16 - fade_sat;

    always_comb
    begin
        if (vc_reg == '0)
        begin
            cnt_sat = CW'(1);
        end
        else if (32'(vc_reg) > 32'(MAX_VOICES))
        begin
            cnt_sat = CW'(MAX_VOICES);
        end
        else
        begin
            cnt_sat = CW'(vc_reg);
        end
    end

    assign last_voice = ((CW'(voice_reg) + CW'(1)) == cnt_sat);

    // phase of the current voice; an entry never written since a clear is zero
    assign ph_cur      = phv_reg[voice_reg] ? ph_q_reg : '0;
    assign ph_new      = ph_cur + inc_reg + step_acc_reg[ACC_W-1:uwco_pkg::Q16_BITS];
    assign tbl_rd_addr = (state_reg == S_IDX) ? ph_cur[PW-1:FB] : nxt_reg;

    assign prod_full = PROD_W'(inc_reg) * PROD_W'(det_sat);

    // lerp: first beat weights entry a by (1 - f), second weights entry b by f
    assign lerp_w = (state_reg == S_NXT) ? (uwco_pkg::FRAC_ONE - {1'b0, frac_reg})
                                         : {1'b0, frac_reg};
    assign t1 = $signed(tbl_q_reg[SB-1:0]);
    assign t2 = $signed(tbl_q_reg[2*SB-1:SB]);
    assign p1 = LW'(t1) * LW'($signed({1'b0, lerp_w}));
    assign p2 = LW'(t2) * LW'($signed({1'b0, lerp_w}));
    assign s1 = LW'(i1_reg) + p1;
    assign s2 = LW'(i2_reg) + p2;

    assign q1 = MW'(i1_reg) * MW'($signed({1'b0, fade_inv}));
    assign q2 = MW'(i2_reg) * MW'($signed({1'b0, fade_sat}));

    assign absv   = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
    assign div_sh = {rem_reg, quo_reg[MAG_W-1]};
    assign div_ge = (div_sh >= {1'b0, cnt_sat});

    assign pos_big = (quo_reg > MAG_W'(uwco_pkg::SAMPLE_MAX_I));
    assign neg_big = (quo_reg > MAG_W'(uwco_pkg::SAMPLE_MAX_I + 1));

    always_comb
    begin
        state_next     = state_reg;
        voice_next     = voice_reg;
        phv_next       = phv_reg;
        inc_next       = inc_reg;
        det_next       = det_reg;
        fade_next      = fade_reg;
        vc_next        = vc_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        prod_next      = prod_reg;
        step_acc_next  = step_acc_reg;
        frac_next      = frac_reg;
        nxt_next       = nxt_reg;
        i1_next        = i1_reg;
        i2_next        = i2_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        mix_next       = mix_reg;
        total_next     = total_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        sample_next    = sample_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                uwco_pkg::REG_INC:    inc_next  = cfg_data[uwco_pkg::INC_W-1:0];
                uwco_pkg::REG_DET:    det_next  = cfg_data[uwco_pkg::DET_W-1:0];
                uwco_pkg::REG_FADE:   fade_next = cfg_data[uwco_pkg::FADE_W-1:0];
                uwco_pkg::REG_VCOUNT:
                begin
                    vc_next  = cfg_data[uwco_pkg::VC_W-1:0];
                    phv_next = '0;
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        uwco_pkg::CMD_TICK:  state_next = S_START;
                        uwco_pkg::CMD_CLEAR: phv_next   = '0;
                        default: ;
                    endcase
                end
            end
            S_START:
            begin
                prod_next     = prod_full[ACC_W-1:0];
                step_acc_next = '0;
                total_next    = '0;
                voice_next    = '0;
                state_next    = S_PH_RD;
            end
            S_PH_RD:
            begin
                state_next = S_IDX;
            end
            S_IDX:
            begin
                phv_next[voice_reg] = 1'b1;
                step_acc_next       = step_acc_reg + prod_reg;
                nxt_next            = ph_cur[PW-1:FB] + AW'(1);
                frac_next           = ph_cur[FB-1:0];
                state_next          = S_NXT;
            end
            S_NXT:
            begin
                i1_next    = p1[IW-1:0];
                i2_next    = p2[IW-1:0];
                state_next = S_LERP;
            end
            S_LERP:
            begin
                i1_next    = s1[IW-1:0];
                i2_next    = s2[IW-1:0];
                state_next = S_MIX;
            end
            S_MIX:
            begin
                m1_next    = q1;
                m2_next    = q2;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                mix_next   = m1_reg + m2_reg;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // arithmetic shift gives the floor of mix / 2^F
                total_next = total_reg + TOT_W'($signed(mix_reg[MW-1:FB]));
                if (last_voice)
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    voice_next = voice_reg + VW'(1);
                    state_next = S_PH_RD;
                end
            end
            S_DIV_INIT:
            begin
                // truncation toward zero: divide the magnitude, restore the sign
                neg_next   = total_reg[TOT_W-1];
                quo_next   = absv[TOT_W-1:uwco_pkg::Q16_BITS];
                rem_next   = '0;
                dcnt_next  = DC_W'(MAG_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = div_ge ? CW'(div_sh - {1'b0, cnt_sat}) : div_sh[CW-1:0];
                quo_next = {quo_reg[MAG_W-2:0], div_ge};
                if (dcnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    dcnt_next = dcnt_reg - DC_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (neg_reg)
                    begin
                        sample_next = neg_big ? uwco_pkg::SAMPLE_MIN : -$signed(quo_reg[SB-1:0]);
                    end
                    else
                    begin
                        sample_next = pos_big ? uwco_pkg::SAMPLE_MAX : $signed(quo_reg[SB-1:0]);
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            voice_reg     <= '0;
            phv_reg       <= '0;
            inc_reg       <= '0;
            det_reg       <= '0;
            fade_reg      <= '0;
            vc_reg        <= uwco_pkg::VC_W'(1);
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            voice_reg     <= voice_next;
            phv_reg       <= phv_next;
            inc_reg       <= inc_next;
            det_reg       <= det_next;
            fade_reg      <= fade_next;
            vc_reg        <= vc_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        step_acc_reg <= step_acc_next;
        frac_reg     <= frac_next;
        nxt_reg      <= nxt_next;
        i1_reg       <= i1_next;
        i2_reg       <= i2_next;
        m1_reg       <= m1_next;
        m2_reg       <= m2_next;
        mix_reg      <= mix_next;
        total_reg    <= total_next;
        neg_reg      <= neg_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        sample_reg   <= sample_next;
    end

    // both tables share one word per entry, first table in the low half
    always_ff @(posedge clk)
    begin
        if (tbl_we_a)
        begin
            tbl_mem[table_address][SB-1:0] <= table_value;
        end
        if (tbl_we_b)
        begin
            tbl_mem[table_address][2*SB-1:SB] <= table_value;
        end
        tbl_q_reg <= tbl_mem[tbl_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ph_we)
        begin
            ph_mem[voice_reg] <= ph_new;
        end
        ph_q_reg <= ph_mem[voice_reg];
    end

endmodule

`default_nettype wire

### rtl/uwco_checker.sv
// Port-level checks of the unison wavetable oscillator, bound to the top level
`default_nettype none

`include "unison_wavetable_crossfade_oscillator_defines.svh"

module uwco_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire uwco_pkg::cmd_t    command,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire uwco_pkg::sample_t audio_sample
);

    // a stalled output beat holds
    `UWCO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(audio_sample))

    // a tick keeps the block busy for at least the following cycle
    `UWCO_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && command == uwco_pkg::CMD_TICK, !in_ready)

    // table writes and phase clears leave the block ready again in the next cycle
    `UWCO_ASSERT_NEXT(a_cmd_quick, in_valid && in_ready && command != uwco_pkg::CMD_TICK, in_ready)

    // a new sample appears only as the block goes back to accepting
    `UWCO_ASSERT_NOW(a_out_idle, $rose(out_valid), in_ready)

endmodule

bind unison_wavetable_crossfade_oscillator uwco_checker u_uwco_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .audio_sample (audio_sample)
);

`default_nettype wire
